>>> design/rrs_pkg.sv
// Shared constants, codes and types of the read response segmenter.
`default_nettype none
package rrs_pkg;

   localparam int PSN_W           = 24;
   localparam int LEN_W           = 32;
   localparam int OFF_W           = 18;
   localparam int PLEN_W          = 13;
   localparam int SHIFT_W         = 4;
   localparam int MTU_MIN_SHIFT   = 8;
   localparam int MTU_MAX_SHIFT   = 12;
   localparam int MTU_RESET_SHIFT = 10;
   localparam int MAX_SEGMENTS_DEF = 64;

   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,
      KIND_MIDDLE = 2'd1,
      KIND_LAST   = 2'd2,
      KIND_ONLY   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SYN_ACK     = 2'd0,
      SYN_PSN_SEQ = 2'd1,
      SYN_INVALID = 2'd2,
      SYN_ACCESS  = 2'd3
   } syndrome_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic [PLEN_W-1:0]  bytes;
   } mtu_info_type;

   typedef struct packed {
      logic              fin;
      logic [PLEN_W-1:0] len;
      logic [1:0]        pad;
      logic [LEN_W-1:0]  rem_next;
      logic [OFF_W-1:0]  off_next;
   } step_type;

endpackage
`default_nettype wire

>>> design/rrs_if.sv
// Request and response channel interfaces of the read response segmenter.
`default_nettype none
interface rrs_req_if
   import rrs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PSN_W-1:0] req_psn;
   logic [LEN_W-1:0] read_len;
   logic             qp_ready;
   logic             reth_present;
   logic             access_ok;

   modport source (output valid, req_psn, read_len, qp_ready, reth_present, access_ok,
                   input ready);
   modport sink (input valid, req_psn, read_len, qp_ready, reth_present, access_ok,
                 output ready);
endinterface

interface rrs_rsp_if
   import rrs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              is_nak;
   logic [1:0]        syndrome;
   logic [1:0]        resp_kind;
   logic [PSN_W-1:0]  psn;
   logic [OFF_W-1:0]  payload_offset;
   logic [PLEN_W-1:0] payload_len;
   logic [1:0]        pad_bytes;
   logic              aeth_present;
   logic              last;

   modport source (output valid, is_nak, syndrome, resp_kind, psn, payload_offset,
                   payload_len, pad_bytes, aeth_present, last,
                   input ready);
   modport sink (input valid, is_nak, syndrome, resp_kind, psn, payload_offset,
                 payload_len, pad_bytes, aeth_present, last,
                 output ready);
endinterface
`default_nettype wire

>>> design/rrs_mtu_cfg.sv
// MTU register that keeps the effective power-of-two MTU as a shift amount.
`default_nettype none
module rrs_mtu_cfg
   import rrs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [PLEN_W-1:0] csr_wr_data,
   output mtu_info_type           mtu
);

   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;

   always_comb begin
      shift_in = shift_ff;
      if (csr_wr_en) begin
         if (csr_wr_data[12]) begin
            shift_in = SHIFT_W'(MTU_MAX_SHIFT);
         end else if (csr_wr_data[11]) begin
            shift_in = SHIFT_W'(11);
         end else if (csr_wr_data[10]) begin
            shift_in = SHIFT_W'(10);
         end else if (csr_wr_data[9]) begin
            shift_in = SHIFT_W'(9);
         end else begin
            shift_in = SHIFT_W'(MTU_MIN_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_W'(MTU_RESET_SHIFT);
      end else begin
         shift_ff <= shift_in;
      end
   end

   assign mtu.shift = shift_ff;
   assign mtu.bytes = PLEN_W'(1) << shift_ff;

endmodule
`default_nettype wire

>>> design/rrs_seg_step.sv
// Step unit that cuts one segment off the remaining length.
`default_nettype none
module rrs_seg_step
   import rrs_pkg::*;
(
   input  wire logic [LEN_W-1:0] rem,
   input  wire logic [OFF_W-1:0] off,
   input  wire mtu_info_type     mtu,
   output step_type              step
);

   always_comb begin
      step.fin      = (rem <= LEN_W'(mtu.bytes));
      step.len      = step.fin ? rem[PLEN_W-1:0] : mtu.bytes;
      step.pad      = step.fin ? 2'(2'd0 - step.len[1:0]) : 2'd0;
      step.rem_next = rem - LEN_W'(step.len);
      step.off_next = off + OFF_W'(step.len);
   end

endmodule
`default_nettype wire

>>> design/rrs_seq.sv
// Sequencer that checks a request and issues its NAK or response words.
`default_nettype none
module rrs_seq
   import rrs_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mtu_info_type mtu,
   rrs_req_if.sink           req_chan,
   rrs_rsp_if.source         rsp_chan
);

   localparam int LIM_W = $clog2(MAX_SEGMENTS + 1) + MTU_MAX_SHIFT;

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_EMIT} state_type;

   state_type         state_ff, state_in;
   logic [PSN_W-1:0]  rpsn_ff, rpsn_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;
   logic              rqp_ff, rqp_in;
   logic              rreth_ff, rreth_in;
   logic              racc_ff, racc_in;
   logic [PSN_W-1:0]  expected_ff, expected_in;
   logic [PSN_W-1:0]  send_ff, send_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              first_ff, first_in;
   logic              ovalid_ff, ovalid_in;
   logic              onak_ff, onak_in;
   syndrome_type      osyn_ff, osyn_in;
   kind_type          okind_ff, okind_in;
   logic [PSN_W-1:0]  opsn_ff, opsn_in;
   logic [OFF_W-1:0]  ooff_ff, ooff_in;
   logic [PLEN_W-1:0] olen_ff, olen_in;
   logic [1:0]        opad_ff, opad_in;
   logic              oaeth_ff, oaeth_in;
   logic              olast_ff, olast_in;

   logic              slot_free;
   logic              nak_any;
   syndrome_type      nak_syn;
   logic [PSN_W-1:0]  nak_psn;
   logic [LIM_W-1:0]  limit;
   step_type          step;

   rrs_seg_step u_step (
      .rem  (rem_ff),
      .off  (off_ff),
      .mtu  (mtu),
      .step (step)
   );

   always_comb begin
      limit     = LIM_W'(MAX_SEGMENTS) << mtu.shift;
      slot_free = !ovalid_ff || rsp_chan.ready;
      nak_any   = 1'b1;
      nak_syn   = SYN_INVALID;
      nak_psn   = rpsn_ff;
      if (!rqp_ff) begin
         nak_syn = SYN_INVALID;
      end else if (rpsn_ff != expected_ff) begin
         nak_syn = SYN_PSN_SEQ;
         nak_psn = expected_ff;
      end else if (!rreth_ff) begin
         nak_syn = SYN_INVALID;
      end else if (!racc_ff) begin
         nak_syn = SYN_ACCESS;
      end else if (rlen_ff > LEN_W'(limit)) begin
         nak_syn = SYN_INVALID;
      end else begin
         nak_any = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      rpsn_in     = rpsn_ff;
      rlen_in     = rlen_ff;
      rqp_in      = rqp_ff;
      rreth_in    = rreth_ff;
      racc_in     = racc_ff;
      expected_in = expected_ff;
      send_in     = send_ff;
      rem_in      = rem_ff;
      off_in      = off_ff;
      first_in    = first_ff;
      ovalid_in   = ovalid_ff && !rsp_chan.ready;
      onak_in     = onak_ff;
      osyn_in     = osyn_ff;
      okind_in    = okind_ff;
      opsn_in     = opsn_ff;
      ooff_in     = ooff_ff;
      olen_in     = olen_ff;
      opad_in     = opad_ff;
      oaeth_in    = oaeth_ff;
      olast_in    = olast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               rpsn_in  = req_chan.req_psn;
               rlen_in  = req_chan.read_len;
               rqp_in   = req_chan.qp_ready;
               rreth_in = req_chan.reth_present;
               racc_in  = req_chan.access_ok;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (nak_any) begin
               if (slot_free) begin
                  ovalid_in = 1'b1;
                  onak_in   = 1'b1;
                  osyn_in   = nak_syn;
                  okind_in  = KIND_FIRST;
                  opsn_in   = nak_psn;
                  ooff_in   = '0;
                  olen_in   = '0;
                  opad_in   = '0;
                  oaeth_in  = 1'b0;
                  olast_in  = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               expected_in = expected_ff + PSN_W'(1);
               rem_in      = rlen_ff;
               off_in      = '0;
               first_in    = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               ovalid_in = 1'b1;
               onak_in   = 1'b0;
               osyn_in   = SYN_ACK;
               if (first_ff && step.fin) begin
                  okind_in = KIND_ONLY;
               end else if (first_ff) begin
                  okind_in = KIND_FIRST;
               end else if (step.fin) begin
                  okind_in = KIND_LAST;
               end else begin
                  okind_in = KIND_MIDDLE;
               end
               opsn_in  = send_ff;
               ooff_in  = off_ff;
               olen_in  = step.len;
               opad_in  = step.pad;
               oaeth_in = first_ff;
               olast_in = step.fin;
               send_in  = send_ff + PSN_W'(1);
               rem_in   = step.rem_next;
               off_in   = step.off_next;
               first_in = 1'b0;
               if (step.fin) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         expected_ff <= '0;
         send_ff     <= '0;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         send_ff     <= send_in;
         ovalid_ff   <= ovalid_in;
      end
      rpsn_ff  <= rpsn_in;
      rlen_ff  <= rlen_in;
      rqp_ff   <= rqp_in;
      rreth_ff <= rreth_in;
      racc_ff  <= racc_in;
      rem_ff   <= rem_in;
      off_ff   <= off_in;
      first_ff <= first_in;
      onak_ff  <= onak_in;
      osyn_ff  <= osyn_in;
      okind_ff <= okind_in;
      opsn_ff  <= opsn_in;
      ooff_ff  <= ooff_in;
      olen_ff  <= olen_in;
      opad_ff  <= opad_in;
      oaeth_ff <= oaeth_in;
      olast_ff <= olast_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = ovalid_ff;
   assign rsp_chan.is_nak         = onak_ff;
   assign rsp_chan.syndrome       = osyn_ff;
   assign rsp_chan.resp_kind      = okind_ff;
   assign rsp_chan.psn            = opsn_ff;
   assign rsp_chan.payload_offset = ooff_ff;
   assign rsp_chan.payload_len    = olen_ff;
   assign rsp_chan.pad_bytes      = opad_ff;
   assign rsp_chan.aeth_present   = oaeth_ff;
   assign rsp_chan.last           = olast_ff;

   // Each issued response word consumes exactly one send PSN.
   a_send_psn_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=> send_ff == PSN_W'($past(send_ff) + 1'b1))
      else $error("send PSN did not advance by one on a response word");

   a_nak_is_last: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && onak_ff) |-> (olast_ff && !oaeth_ff && olen_ff == '0))
      else $error("NAK word carries descriptor fields");

   a_aeth_kind: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && oaeth_ff) |-> (okind_ff == KIND_FIRST || okind_ff == KIND_ONLY))
      else $error("AETH on a middle or last word");

   a_pad_last: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && opad_ff != 2'd0) |-> olast_ff)
      else $error("pad bytes on a word that is not final");

   a_expected_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CHECK) |=> $stable(expected_ff))
      else $error("expected PSN moved outside the check step");

endmodule
`default_nettype wire

>>> design/rdma_read_responder_segmenter_top.sv
// Top level of the read responder segmenter for one queue pair.
// A request is accepted, checked in the next cycle, and a NAK word is registered
// at the end of the check when the output slot is free; response words come from the emit state.
// A new request is taken only after the last word of the previous one is registered;
// one response word a cycle while the output is not stalled.
// Reset clears both PSN counters and sets the MTU register to 1024 bytes.
`default_nettype none
module rdma_read_responder_segmenter_top
   import rrs_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   rrs_req_if.sink                req_chan,
   rrs_rsp_if.source              rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [PLEN_W-1:0] csr_wr_data
);

   mtu_info_type mtu;

   rrs_mtu_cfg u_mtu_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mtu         (mtu)
   );

   rrs_seq #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .mtu      (mtu),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
